FILE: rtl/gbn_pkg.sv
// gbn_pkg: shared types and constants of the go-back-n sender window core
// no dependencies; used by gbn_ctrl, gbn_datapath and the top level
package gbn_pkg;

  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned SLOT_OUT_W = 5;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CNT_W      = $clog2(MAX_RESULTS + 1);

  // request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_OFFER   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND    = 2'd0,
    KIND_RESEND  = 2'd1,
    KIND_REFUSED = 2'd2,
    KIND_STATUS  = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RESEND = 1'b1
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_OFFER   = 3'd1,
    CMD_ACK     = 3'd2,
    CMD_STATUS  = 3'd3,
    CMD_RS_LOAD = 3'd4,
    CMD_RS_STEP = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic outstanding;  // base differs from next sequence
    logic rs_last;      // current resend step is the final one
  } dp_status_t;

endpackage

FILE: rtl/gbn_ctrl.sv
// gbn_ctrl: controller state machine of the go-back-n sender window core
// depends on gbn_pkg; drives gbn_datapath through a command struct
module gbn_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [gbn_pkg::REQ_W-1:0] req_type,
  input  gbn_pkg::dp_status_t      status,
  output logic                     busy,
  output gbn_pkg::ctrl_cmd_t       cmd
);

  gbn_pkg::state_t state_r;
  gbn_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = gbn_pkg::CMD_NONE;
    busy      = 1'b0;
    case (state_r)
      gbn_pkg::ST_IDLE: begin
        if (start) begin
          case (req_type)
            gbn_pkg::REQ_OFFER: cmd.op = gbn_pkg::CMD_OFFER;
            gbn_pkg::REQ_ACK:   cmd.op = gbn_pkg::CMD_ACK;
            gbn_pkg::REQ_TIMEOUT: begin
              if (status.outstanding) begin
                cmd.op    = gbn_pkg::CMD_RS_LOAD;
                state_nxt = gbn_pkg::ST_RESEND;
              end else begin
                cmd.op = gbn_pkg::CMD_STATUS;
              end
            end
            default: cmd.op = gbn_pkg::CMD_STATUS;
          endcase
        end
      end
      gbn_pkg::ST_RESEND: begin
        busy   = 1'b1;
        cmd.op = gbn_pkg::CMD_RS_STEP;
        if (status.rs_last) begin
          state_nxt = gbn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gbn_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/gbn_datapath.sv
// gbn_datapath: window registers, slot length memory and result registers
// depends on gbn_pkg; commanded by gbn_ctrl
module gbn_datapath #(
  parameter int unsigned WINDOW      = 32,
  parameter int unsigned CHUNK_BYTES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gbn_pkg::ctrl_cmd_t            cmd,
  input  logic [gbn_pkg::LEN_W-1:0]     chunk_len,
  input  logic [gbn_pkg::SEQ_W-1:0]     ack_seq,
  input  logic [gbn_pkg::SEQ_W-1:0]     total_size,
  output gbn_pkg::dp_status_t           status,
  output logic                          res_strobe,
  output logic [gbn_pkg::KIND_W-1:0]    res_kind,
  output logic [gbn_pkg::SEQ_W-1:0]     res_seq,
  output logic [gbn_pkg::SLOT_OUT_W-1:0] res_slot,
  output logic [gbn_pkg::LEN_W-1:0]     res_pkt_len,
  output logic [gbn_pkg::SEQ_W-1:0]     res_window_base,
  output logic                          res_all_done,
  output logic                          res_last
);

  localparam int unsigned SLOT_W = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int unsigned OFF_W  = SLOT_W + 1;
  localparam int unsigned CB_W   = 17;
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(WINDOW - 1);

  // window state
  logic [gbn_pkg::SEQ_W-1:0] base_r, base_nxt;
  logic [gbn_pkg::SEQ_W-1:0] next_seq_r, next_seq_nxt;
  logic [gbn_pkg::SEQ_W-1:0] bytes_sent_r, bytes_sent_nxt;
  logic [SLOT_W-1:0]         base_slot_r, base_slot_nxt;
  logic [SLOT_W-1:0]         next_slot_r, next_slot_nxt;

  // resend walker
  logic [gbn_pkg::SEQ_W-1:0] rs_seq_r, rs_seq_nxt;
  logic [SLOT_W-1:0]         rs_slot_r, rs_slot_nxt;
  logic [gbn_pkg::CNT_W-1:0] rs_left_r, rs_left_nxt;

  // result registers
  logic                           strobe_r, strobe_nxt;
  logic [gbn_pkg::KIND_W-1:0]     kind_r, kind_nxt;
  logic [gbn_pkg::SEQ_W-1:0]      seq_r, seq_nxt;
  logic [SLOT_W-1:0]              slot_r, slot_nxt;
  logic [gbn_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic                           last_r, last_nxt;
  logic                           from_mem_r, from_mem_nxt;

  // slot length store
  logic [gbn_pkg::LEN_W-1:0] slot_mem [WINDOW];
  logic [gbn_pkg::LEN_W-1:0] rd_data_r;

  logic [gbn_pkg::SEQ_W-1:0] in_flight;
  logic [gbn_pkg::SEQ_W-1:0] ack_off;
  logic [OFF_W-1:0]          off_sum;
  logic [gbn_pkg::LEN_W-1:0] clip_len;
  logic [gbn_pkg::SEQ_W:0]   bytes_sum;
  logic                      offer_ok;
  logic                      ack_ok;
  logic                      mem_wr;

  assign in_flight = next_seq_r - base_r;
  assign ack_off   = ack_seq - base_r;
  assign ack_ok    = (ack_seq >= base_r) && (ack_seq < next_seq_r);
  // offset of ack+1 from base is at most WINDOW
  assign off_sum   = OFF_W'(base_slot_r) + OFF_W'(ack_off) + OFF_W'(1);

  assign offer_ok = (in_flight < gbn_pkg::SEQ_W'(WINDOW)) &&
                    (bytes_sent_r < total_size) &&
                    (next_seq_r != {gbn_pkg::SEQ_W{1'b1}});

  assign clip_len = (CB_W'(chunk_len) < CB_W'(CHUNK_BYTES)) ?
                    chunk_len : gbn_pkg::LEN_W'(CHUNK_BYTES);
  assign bytes_sum = {1'b0, bytes_sent_r} + (gbn_pkg::SEQ_W + 1)'(clip_len);

  assign mem_wr = (cmd.op == gbn_pkg::CMD_OFFER) && offer_ok;

  always_comb begin
    base_nxt       = base_r;
    next_seq_nxt   = next_seq_r;
    bytes_sent_nxt = bytes_sent_r;
    base_slot_nxt  = base_slot_r;
    next_slot_nxt  = next_slot_r;
    rs_seq_nxt     = rs_seq_r;
    rs_slot_nxt    = rs_slot_r;
    rs_left_nxt    = rs_left_r;
    strobe_nxt     = 1'b0;
    kind_nxt       = kind_r;
    seq_nxt        = seq_r;
    slot_nxt       = slot_r;
    len_nxt        = len_r;
    last_nxt       = last_r;
    from_mem_nxt   = from_mem_r;
    case (cmd.op)
      gbn_pkg::CMD_OFFER: begin
        strobe_nxt   = 1'b1;
        seq_nxt      = next_seq_r;
        slot_nxt     = next_slot_r;
        last_nxt     = 1'b1;
        from_mem_nxt = 1'b0;
        if (offer_ok) begin
          kind_nxt       = gbn_pkg::KIND_SEND;
          len_nxt        = clip_len;
          next_seq_nxt   = next_seq_r + gbn_pkg::SEQ_W'(1);
          next_slot_nxt  = (next_slot_r == SLOT_MAX) ? '0 : next_slot_r + SLOT_W'(1);
          bytes_sent_nxt = bytes_sum[gbn_pkg::SEQ_W] ? {gbn_pkg::SEQ_W{1'b1}}
                                                     : bytes_sum[gbn_pkg::SEQ_W-1:0];
        end else begin
          kind_nxt = gbn_pkg::KIND_REFUSED;
          len_nxt  = '0;
        end
      end
      gbn_pkg::CMD_ACK, gbn_pkg::CMD_STATUS: begin
        strobe_nxt   = 1'b1;
        kind_nxt     = gbn_pkg::KIND_STATUS;
        seq_nxt      = next_seq_r;
        slot_nxt     = '0;
        len_nxt      = '0;
        last_nxt     = 1'b1;
        from_mem_nxt = 1'b0;
        if ((cmd.op == gbn_pkg::CMD_ACK) && ack_ok) begin
          base_nxt      = ack_seq + gbn_pkg::SEQ_W'(1);
          base_slot_nxt = (off_sum >= OFF_W'(WINDOW)) ? SLOT_W'(off_sum - OFF_W'(WINDOW))
                                                      : SLOT_W'(off_sum);
        end
      end
      gbn_pkg::CMD_RS_LOAD: begin
        rs_seq_nxt  = base_r;
        rs_slot_nxt = base_slot_r;
        rs_left_nxt = (in_flight > gbn_pkg::SEQ_W'(gbn_pkg::MAX_RESULTS)) ?
                      gbn_pkg::CNT_W'(gbn_pkg::MAX_RESULTS) : gbn_pkg::CNT_W'(in_flight);
      end
      gbn_pkg::CMD_RS_STEP: begin
        strobe_nxt   = 1'b1;
        kind_nxt     = gbn_pkg::KIND_RESEND;
        seq_nxt      = rs_seq_r;
        slot_nxt     = rs_slot_r;
        last_nxt     = (rs_left_r == gbn_pkg::CNT_W'(1));
        from_mem_nxt = 1'b1;
        rs_seq_nxt   = rs_seq_r + gbn_pkg::SEQ_W'(1);
        rs_slot_nxt  = (rs_slot_r == SLOT_MAX) ? '0 : rs_slot_r + SLOT_W'(1);
        rs_left_nxt  = rs_left_r - gbn_pkg::CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      next_seq_r   <= '0;
      bytes_sent_r <= '0;
      base_slot_r  <= '0;
      next_slot_r  <= '0;
      rs_left_r    <= '0;
      strobe_r     <= 1'b0;
      from_mem_r   <= 1'b0;
    end else begin
      base_r       <= base_nxt;
      next_seq_r   <= next_seq_nxt;
      bytes_sent_r <= bytes_sent_nxt;
      base_slot_r  <= base_slot_nxt;
      next_slot_r  <= next_slot_nxt;
      rs_left_r    <= rs_left_nxt;
      strobe_r     <= strobe_nxt;
      from_mem_r   <= from_mem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_seq_r  <= rs_seq_nxt;
    rs_slot_r <= rs_slot_nxt;
    kind_r    <= kind_nxt;
    seq_r     <= seq_nxt;
    slot_r    <= slot_nxt;
    len_r     <= len_nxt;
    last_r    <= last_nxt;
  end

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      slot_mem[next_slot_r] <= clip_len;
    end
    if (cmd.op == gbn_pkg::CMD_RS_STEP) begin
      rd_data_r <= slot_mem[rs_slot_r];
    end
  end

  assign status.outstanding = (base_r != next_seq_r);
  assign status.rs_last     = (rs_left_r == gbn_pkg::CNT_W'(1));

  assign res_strobe      = strobe_r;
  assign res_kind        = kind_r;
  assign res_seq         = seq_r;
  assign res_slot        = gbn_pkg::SLOT_OUT_W'(slot_r);
  assign res_pkt_len     = from_mem_r ? rd_data_r : len_r;
  assign res_last        = last_r;
  // state already holds the post-step values while the result is shown
  assign res_window_base = base_r;
  assign res_all_done    = (bytes_sent_r >= total_size) && (base_r == next_seq_r);

endmodule

FILE: rtl/go_back_n_sender_window_core.sv
// go_back_n_sender_window_core: top level of the go-back-n sender window
// depends on gbn_pkg, gbn_ctrl and gbn_datapath; holds the apb register
//
// A request is taken at a rising edge with start high and busy low. Offers,
// acks, the unused request code and timeouts with nothing outstanding give
// one result, registered at the edge that takes the request and shown on the
// out_ ports for exactly one cycle with out_strobe high; busy stays low, so
// such requests may follow every cycle. A timeout with n sequences
// outstanding (n capped at 32) holds busy while the walker steps: the
// accepting edge loads the resend walker, then the walker emits n resends,
// one per cycle, from the slot length memory, whose registered read is taken
// together with the other result registers, so each resend shows in the cycle
// after its step; the final resend carries out_last. Results cannot be held off, so
// the receiver must take every strobe. out_window_base and out_all_done
// reflect the window after the request. total_size sits at byte address 0 of
// the apb port and should only be written while no request is being worked on.
module go_back_n_sender_window_core #(
  parameter int unsigned WINDOW      = 32,
  parameter int unsigned CHUNK_BYTES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic [gbn_pkg::REQ_W-1:0]       in_req_type,
  input  logic [gbn_pkg::LEN_W-1:0]       in_chunk_len,
  input  logic [gbn_pkg::SEQ_W-1:0]       in_ack_seq,
  // result channel
  output logic                            out_strobe,
  output logic [gbn_pkg::KIND_W-1:0]      out_kind,
  output logic [gbn_pkg::SEQ_W-1:0]       out_seq,
  output logic [gbn_pkg::SLOT_OUT_W-1:0]  out_slot,
  output logic [gbn_pkg::LEN_W-1:0]       out_pkt_len,
  output logic [gbn_pkg::SEQ_W-1:0]       out_window_base,
  output logic                            out_all_done,
  output logic                            out_last,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  gbn_pkg::ctrl_cmd_t  cmd;
  gbn_pkg::dp_status_t status;

  logic [gbn_pkg::SEQ_W-1:0] total_size_r;
  logic                      cfg_wr;
  logic                      cfg_hit;

  // register index 0 covers byte addresses 0 to 3
  assign cfg_hit = (paddr[2] == 1'b0);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? total_size_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_size_r <= '0;
    end else if (cfg_wr) begin
      total_size_r <= pwdata;
    end
  end

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  gbn_datapath #(
    .WINDOW      (WINDOW),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .chunk_len       (in_chunk_len),
    .ack_seq         (in_ack_seq),
    .total_size      (total_size_r),
    .status          (status),
    .res_strobe      (out_strobe),
    .res_kind        (out_kind),
    .res_seq         (out_seq),
    .res_slot        (out_slot),
    .res_pkt_len     (out_pkt_len),
    .res_window_base (out_window_base),
    .res_all_done    (out_all_done),
    .res_last        (out_last)
  );

endmodule

FILE: sim/tb_top.sv
// tb_top: self-checking testbench for go_back_n_sender_window_core
// depends on gbn_pkg and the core rtl; needs no files and no arguments
// named tests drive offers, acks and timeouts against an in-bench window model
module tb_top;

  localparam int unsigned WINDOW      = 32;
  localparam int unsigned CHUNK_BYTES = 1024;
  localparam logic [gbn_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] TOTAL_SIZE_ADDR  = 3'd0;

  // one expected packet descriptor on the result channel
  typedef struct {
    gbn_pkg::kind_t             kind;
    logic [gbn_pkg::SEQ_W-1:0]  seq;
    logic [4:0]                 slot;
    logic [gbn_pkg::LEN_W-1:0]  pkt_len;
    logic [gbn_pkg::SEQ_W-1:0]  base;
    logic                       all_done;
    logic                       last;
  } pkt_t;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic [gbn_pkg::REQ_W-1:0]       in_req_type;
  logic [gbn_pkg::LEN_W-1:0]       in_chunk_len;
  logic [gbn_pkg::SEQ_W-1:0]       in_ack_seq;
  logic                            out_strobe;
  logic [gbn_pkg::KIND_W-1:0]      out_kind;
  logic [gbn_pkg::SEQ_W-1:0]       out_seq;
  logic [gbn_pkg::SLOT_OUT_W-1:0]  out_slot;
  logic [gbn_pkg::LEN_W-1:0]       out_pkt_len;
  logic [gbn_pkg::SEQ_W-1:0]       out_window_base;
  logic                            out_all_done;
  logic                            out_last;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [2:0]                      paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;

  // window model state, mirrors the core after every accepted request
  logic [gbn_pkg::SEQ_W-1:0]  win_base;
  logic [gbn_pkg::SEQ_W-1:0]  seq_next;
  logic [31:0]                sent_bytes;
  logic [31:0]                xfer_size;
  logic [gbn_pkg::LEN_W-1:0]  len_by_slot [WINDOW];

  pkt_t pending_pkts [$];
  int   mismatch_count;
  int   idle_pct;

  go_back_n_sender_window_core #(
    .WINDOW      (WINDOW),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_chunk_len    (in_chunk_len),
    .in_ack_seq      (in_ack_seq),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_seq         (out_seq),
    .out_slot        (out_slot),
    .out_pkt_len     (out_pkt_len),
    .out_window_base (out_window_base),
    .out_all_done    (out_all_done),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // hard stop in case the core hangs or stops taking requests
  initial begin
    #(12 * 400000);
    $display("** go_back_n_sender_window_core: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 60)
      $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    mismatch_count++;
  endtask

  // appends one descriptor; base and completion flag come from the model as it stands
  task automatic queue_pkt(input gbn_pkg::kind_t kind,
                           input logic [gbn_pkg::SEQ_W-1:0] seq,
                           input logic [4:0] slot, input logic [gbn_pkg::LEN_W-1:0] len,
                           input logic last);
    pkt_t p;
    p.kind     = kind;
    p.seq      = seq;
    p.slot     = slot;
    p.pkt_len  = len;
    p.base     = win_base;
    p.all_done = (sent_bytes >= xfer_size) && (win_base == seq_next);
    p.last     = last;
    pending_pkts.push_back(p);
  endtask

  // advances the window model by one accepted request and queues its packets
  task automatic predict_window_step(input logic [gbn_pkg::REQ_W-1:0] req,
                                     input logic [gbn_pkg::LEN_W-1:0] clen,
                                     input logic [gbn_pkg::SEQ_W-1:0] ack);
    logic [gbn_pkg::SEQ_W-1:0] in_flight;
    logic [gbn_pkg::SEQ_W-1:0] burst;
    logic [gbn_pkg::SEQ_W-1:0] s;
    logic [gbn_pkg::LEN_W-1:0] len;
    logic [32:0]               sum;
    in_flight = seq_next - win_base;
    case (req)
      gbn_pkg::REQ_OFFER: begin
        if (in_flight < WINDOW && sent_bytes < xfer_size && seq_next != '1) begin
          len = (clen > CHUNK_BYTES) ? gbn_pkg::LEN_W'(CHUNK_BYTES) : clen;
          s = seq_next;
          len_by_slot[s % WINDOW] = len;
          seq_next = s + 1;
          // byte count saturates rather than wrapping
          sum = {1'b0, sent_bytes} + 33'(len);
          sent_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          queue_pkt(gbn_pkg::KIND_SEND, s, 5'(s % WINDOW), len, 1'b1);
        end else begin
          queue_pkt(gbn_pkg::KIND_REFUSED, seq_next, 5'(seq_next % WINDOW), '0, 1'b1);
        end
      end
      gbn_pkg::REQ_ACK: begin
        // cumulative: only an ack inside the outstanding range moves the base
        if (ack >= win_base && ack < seq_next) win_base = ack + 1;
        queue_pkt(gbn_pkg::KIND_STATUS, seq_next, '0, '0, 1'b1);
      end
      gbn_pkg::REQ_TIMEOUT: begin
        if (in_flight != 0) begin
          burst = (in_flight > gbn_pkg::MAX_RESULTS) ? gbn_pkg::MAX_RESULTS : in_flight;
          for (logic [gbn_pkg::SEQ_W-1:0] k = 0; k < burst; k++) begin
            s = win_base + k;
            queue_pkt(gbn_pkg::KIND_RESEND, s, 5'(s % WINDOW), len_by_slot[s % WINDOW],
                      k + 1 == burst);
          end
        end else begin
          queue_pkt(gbn_pkg::KIND_STATUS, seq_next, '0, '0, 1'b1);
        end
      end
      default: queue_pkt(gbn_pkg::KIND_STATUS, seq_next, '0, '0, 1'b1);
    endcase
  endtask

  // result checker: every strobe is a transfer, compared with the oldest descriptor
  always @(posedge clk) begin : check_results
    pkt_t want;
    if (rst_n && out_strobe) begin
      if (pending_pkts.size() == 0) begin
        report_mismatch("unexpected result seq", out_seq, 32'h0);
      end else begin
        want = pending_pkts.pop_front();
        if (out_kind !== want.kind)            report_mismatch("kind", out_kind, want.kind);
        if (out_seq !== want.seq)              report_mismatch("seq", out_seq, want.seq);
        if (out_slot !== want.slot)            report_mismatch("slot", out_slot, want.slot);
        if (out_pkt_len !== want.pkt_len)      report_mismatch("pkt_len", out_pkt_len,
                                                               want.pkt_len);
        if (out_window_base !== want.base)     report_mismatch("window_base", out_window_base,
                                                               want.base);
        if (out_all_done !== want.all_done)    report_mismatch("all_done", out_all_done,
                                                               want.all_done);
        if (out_last !== want.last)            report_mismatch("last", out_last, want.last);
      end
    end
  end

  // one request transfer: held until the core is not busy at a rising edge
  task automatic send_req(input logic [gbn_pkg::REQ_W-1:0] req,
                          input logic [gbn_pkg::LEN_W-1:0] clen,
                          input logic [gbn_pkg::SEQ_W-1:0] ack);
    @(negedge clk);
    start        <= 1'b1;
    in_req_type  <= req;
    in_chunk_len <= clen;
    in_ack_seq   <= ack;
    do @(posedge clk); while (busy);
    predict_window_step(req, clen, ack);
  endtask

  // random sender idle time, with junk on the fields while start is low
  task automatic sender_gap();
    int n;
    n = 0;
    while (n < 12 && $urandom_range(99) < idle_pct) n++;
    if (n > 0) begin
      @(negedge clk);
      start        <= 1'b0;
      in_req_type  <= gbn_pkg::REQ_W'($urandom);
      in_chunk_len <= gbn_pkg::LEN_W'($urandom);
      in_ack_seq   <= $urandom;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // mostly in-range lengths, some above the chunk limit to hit the clamp
  function automatic logic [gbn_pkg::LEN_W-1:0] pick_chunk_len();
    if ($urandom_range(99) < 75) return gbn_pkg::LEN_W'($urandom_range(0, CHUNK_BYTES));
    return gbn_pkg::LEN_W'($urandom_range(0, (1 << gbn_pkg::LEN_W) - 1));
  endfunction

  task automatic drain_results();
    int n;
    n = 0;
    while (pending_pkts.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  // register write then read-back, only with the core idle
  task automatic write_total_size(input logic [31:0] value);
    @(negedge clk);
    start <= 1'b0;
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOTAL_SIZE_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    xfer_size = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) report_mismatch("total_size read-back", prdata, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // nothing sent yet and nothing allowed: refusal and status-only results
  task automatic test_idle_requests();
    write_total_size(32'h0);
    send_req(gbn_pkg::REQ_OFFER, 11'd100, 32'h0);
    send_req(REQ_UNUSED, 11'h7FF, 32'hFFFF_FFFF);
    send_req(gbn_pkg::REQ_TIMEOUT, 11'd0, 32'h0);
    send_req(gbn_pkg::REQ_ACK, 11'd0, 32'h0);
    send_req(gbn_pkg::REQ_ACK, 11'd0, 32'hFFFF_FFFF);
  endtask

  // length clamp, old and never-sent acks, a partial resend burst
  task automatic test_offer_ack_timeout();
    write_total_size(32'hFFFF_FFFF);
    send_req(gbn_pkg::REQ_OFFER, 11'd0, 32'h0);
    send_req(gbn_pkg::REQ_OFFER, 11'd1024, 32'h0);
    send_req(gbn_pkg::REQ_OFFER, 11'h7FF, 32'h0);
    send_req(gbn_pkg::REQ_OFFER, 11'd1025, 32'h0);
    send_req(gbn_pkg::REQ_OFFER, 11'd1, 32'h0);
    send_req(gbn_pkg::REQ_OFFER, 11'd1023, 32'h0);
    send_req(gbn_pkg::REQ_ACK, 11'd0, 32'd1);
    send_req(gbn_pkg::REQ_ACK, 11'd0, 32'd0);
    send_req(gbn_pkg::REQ_ACK, 11'd0, 32'hFFFF_FFFF);
    send_req(gbn_pkg::REQ_ACK, 11'd0, 32'd7);
    send_req(gbn_pkg::REQ_TIMEOUT, 11'd0, 32'h0);
    send_req(REQ_UNUSED, 11'd0, 32'h0);
    send_req(gbn_pkg::REQ_ACK, 11'd0, seq_next - 1);
    send_req(gbn_pkg::REQ_TIMEOUT, 11'd0, 32'h0);
  endtask

  // total size reached: last offer taken, next refused, final ack completes
  task automatic test_bytes_exhausted();
    write_total_size(sent_bytes + 1);
    send_req(gbn_pkg::REQ_OFFER, 11'd1024, 32'h0);
    send_req(gbn_pkg::REQ_OFFER, 11'd10, 32'h0);
    send_req(gbn_pkg::REQ_ACK, 11'd0, seq_next - 1);
    send_req(gbn_pkg::REQ_TIMEOUT, 11'd0, 32'h0);
  endtask

  // fill every slot, get refused, then a full-length resend burst
  task automatic test_full_window();
    write_total_size(32'hFFFF_FFFF);
    while (seq_next - win_base < WINDOW)
      send_req(gbn_pkg::REQ_OFFER, pick_chunk_len(), $urandom);
    send_req(gbn_pkg::REQ_OFFER, pick_chunk_len(), $urandom);
    send_req(gbn_pkg::REQ_TIMEOUT, pick_chunk_len(), $urandom);
    send_req(gbn_pkg::REQ_ACK, 11'd0, seq_next - 1);
    send_req(gbn_pkg::REQ_TIMEOUT, 11'd0, 32'h0);
  endtask

  // mixed traffic: runs of offers, acks mostly inside the window, timeouts, noise
  task automatic test_random_traffic(input int n_items);
    int                         done_n;
    int                         run;
    int                         pick;
    logic [gbn_pkg::SEQ_W-1:0]  in_flight;
    logic [gbn_pkg::SEQ_W-1:0]  ack;
    done_n = 0;
    while (done_n < n_items) begin
      pick = $urandom_range(99);
      in_flight = seq_next - win_base;
      if (pick < 10) begin
        run = $urandom_range(4, 36);
        repeat (run) begin
          send_req(gbn_pkg::REQ_OFFER, pick_chunk_len(), $urandom);
          sender_gap();
        end
        done_n += run;
      end else begin
        if (pick < 50) begin
          send_req(gbn_pkg::REQ_OFFER, pick_chunk_len(), $urandom);
        end else if (pick < 80) begin
          ack = (in_flight != 0) ? win_base + $urandom_range(0, in_flight - 1) : win_base;
          if (pick < 55) ack = win_base - 1 - $urandom_range(0, 3);
          else if (pick < 59) ack = $urandom;
          send_req(gbn_pkg::REQ_ACK, pick_chunk_len(), ack);
        end else if (pick < 94) begin
          send_req(gbn_pkg::REQ_TIMEOUT, pick_chunk_len(), $urandom);
        end else begin
          send_req(REQ_UNUSED, pick_chunk_len(), $urandom);
        end
        sender_gap();
        done_n++;
      end
    end
  endtask

  initial begin : run_tests
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req_type  = '0;
    in_chunk_len = '0;
    in_ack_seq   = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    win_base     = '0;
    seq_next     = '0;
    sent_bytes   = '0;
    xfer_size    = '0;
    mismatch_count = 0;
    idle_pct     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_requests();
    test_offer_ack_timeout();
    test_bytes_exhausted();
    test_full_window();

    // back-to-back phase, unlimited transfer size
    test_random_traffic(70);
    // sender mostly idle, transfer ends far ahead
    write_total_size(sent_bytes + $urandom_range(20000, 60000));
    idle_pct = 58;
    test_random_traffic(70);
    // light idling, transfer runs out so refusals and completion show up
    write_total_size(sent_bytes + $urandom_range(1, 4000));
    idle_pct = 20;
    test_random_traffic(70);

    @(negedge clk);
    start <= 1'b0;
    drain_results();
    repeat (40) @(posedge clk);
    if (pending_pkts.size() != 0)
      report_mismatch("results never seen", pending_pkts.size(), 32'h0);
    if (mismatch_count == 0) begin
      $display("** go_back_n_sender_window_core: PASSED **");
    end else begin
      $display("** go_back_n_sender_window_core: FAILED **");
    end
    $finish;
  end

endmodule
